FILE: design/ffed_pkg.sv
// Package for the free-fall event detector.
// Holds field widths, reset values, register and event codes and shared types.
// No dependencies; every other file of the block imports it.
package ffed_pkg;

	// Fixed widths of the channel fields
	localparam int ACCEL_FIELD_W = 16;
	localparam int DURATION_W    = 32;
	localparam int THRESHOLD_W   = 16;
	localparam int PERIOD_W      = 10;
	localparam int REPORT_W      = 8;
	localparam int THR2_W        = 2 * THRESHOLD_W;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 16;

	// Default significant bits of each acceleration sample
	localparam int ACCEL_BITS_DEF = 16;

	// Register reset values
	localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 16'd8000;
	localparam logic [PERIOD_W-1:0]    PERIOD_RST    = 10'd100;
	localparam logic [REPORT_W-1:0]    REPORT_RST    = 8'd5;
	localparam logic [THR2_W-1:0]      THR2_RST      =
		THR2_W'(THRESHOLD_RST) * THR2_W'(THRESHOLD_RST);

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_PERIOD    = 2'd1,
		REG_REPORT    = 2'd2
	} cfg_reg_t;

	// Event codes carried by each result
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_STARTED = 2'd1,
		EV_STILL   = 2'd2,
		EV_ENDED   = 2'd3
	} fall_event_t;

	// Live configuration seen by the datapath
	typedef struct packed {
		logic [THR2_W-1:0]   thr2;
		logic [PERIOD_W-1:0] sample_period;
		logic [REPORT_W-1:0] still_report;
	} cfg_t;

	// Compare result handed from the magnitude pipe to the event stage
	typedef struct packed {
		logic valid;
		logic below;
	} mag_flow_t;

endpackage

FILE: design/ffed_if.sv
// Channel interfaces of the free-fall event detector: samples, results, config.
// Each carries valid, ready and its payload; depends on ffed_pkg.

interface ffed_sample_if;
	import ffed_pkg::*;

	logic                            valid;
	logic                            ready;
	logic signed [ACCEL_FIELD_W-1:0] accel_x;
	logic signed [ACCEL_FIELD_W-1:0] accel_y;
	logic signed [ACCEL_FIELD_W-1:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		output ready);
endinterface

interface ffed_result_if;
	import ffed_pkg::*;

	logic                  valid;
	logic                  ready;
	fall_event_t           fall_event;
	logic [DURATION_W-1:0] fall_duration_ms;
	logic                  is_falling;

	modport source (output valid, output fall_event, output fall_duration_ms,
		output is_falling, input ready);
	modport sink (input valid, input fall_event, input fall_duration_ms,
		input is_falling, output ready);
endinterface

interface ffed_cfg_if;
	import ffed_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/ffed_cfg_regs.sv
// Configuration registers of the free-fall event detector.
// Takes writes from the config channel and keeps the squared threshold; uses ffed_pkg.
module ffed_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	ffed_cfg_if.sink           cfg,
	output ffed_pkg::cfg_t     cfg_out
);
	import ffed_pkg::*;

	logic [THRESHOLD_W-1:0] threshold_q;
	logic [PERIOD_W-1:0]    period_q;
	logic [REPORT_W-1:0]    report_q;
	logic [THR2_W-1:0]      thr2_q;
	logic                   wr_en;

	// Writes are always taken
	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid;

	// Update the addressed register; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			period_q    <= PERIOD_RST;
			report_q    <= REPORT_RST;
		end else if (wr_en) begin
			case (cfg.index)
				REG_THRESHOLD: threshold_q <= cfg.data[THRESHOLD_W-1:0];
				REG_PERIOD:    period_q    <= cfg.data[PERIOD_W-1:0];
				REG_REPORT:    report_q    <= cfg.data[REPORT_W-1:0];
				default: ;
			endcase
		end
	end

	// Square the threshold, registered in the cycle after it changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr2_q <= THR2_RST;
		end else begin
			thr2_q <= THR2_W'(threshold_q) * THR2_W'(threshold_q);
		end
	end

	assign cfg_out.thr2          = thr2_q;
	assign cfg_out.sample_period = period_q;
	assign cfg_out.still_report  = report_q;

endmodule

FILE: design/ffed_mag_pipe.sv
// Magnitude pipeline: input register, per-axis squares, sum and threshold compare.
// Three stages with per-stage valid and back-pressure; uses ffed_pkg and ffed_sample_if.
module ffed_mag_pipe #(
	parameter int ACCEL_BITS = ffed_pkg::ACCEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ffed_sample_if.sink               sample,
	input  logic [ffed_pkg::THR2_W-1:0] thr2,
	output ffed_pkg::mag_flow_t       flow,
	input  logic                      flow_ready
);
	import ffed_pkg::*;

	localparam int SQ_W  = 2 * ACCEL_BITS - 1;
	localparam int MAG_W = SQ_W + 2;
	localparam int CMP_W = (MAG_W > THR2_W) ? MAG_W : THR2_W;

	logic                         v_s1, v_s2, v_s3;
	logic                         adv_s1, adv_s2, adv_s3;
	logic signed [ACCEL_BITS-1:0] ax_s1, ay_s1, az_s1;
	logic signed [2*ACCEL_BITS-1:0] prod_x, prod_y, prod_z;
	logic [SQ_W-1:0]              sqx_s2, sqy_s2, sqz_s2;
	logic [MAG_W-1:0]             mag2;
	logic [CMP_W-1:0]             mag_ext, thr_ext;
	logic                         below_s3;

	// A stage moves on when it is empty or its successor moves
	assign adv_s3       = !v_s3 || flow_ready;
	assign adv_s2       = !v_s2 || adv_s3;
	assign adv_s1       = !v_s1 || adv_s2;
	assign sample.ready = adv_s1;

	// Stage 1: capture the sample, keeping the significant bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample.valid) begin
			ax_s1 <= sample.accel_x[ACCEL_BITS-1:0];
			ay_s1 <= sample.accel_y[ACCEL_BITS-1:0];
			az_s1 <= sample.accel_z[ACCEL_BITS-1:0];
		end
	end

	// Stage 2: square each axis; a square never exceeds 2^(2*ACCEL_BITS-2)
	assign prod_x = (2*ACCEL_BITS)'(ax_s1) * (2*ACCEL_BITS)'(ax_s1);
	assign prod_y = (2*ACCEL_BITS)'(ay_s1) * (2*ACCEL_BITS)'(ay_s1);
	assign prod_z = (2*ACCEL_BITS)'(az_s1) * (2*ACCEL_BITS)'(az_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			sqx_s2 <= prod_x[SQ_W-1:0];
			sqy_s2 <= prod_y[SQ_W-1:0];
			sqz_s2 <= prod_z[SQ_W-1:0];
		end
	end

	// Stage 3: sum the squares and compare with the squared threshold
	assign mag2    = {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	assign mag_ext = CMP_W'(mag2);
	assign thr_ext = CMP_W'(thr2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			below_s3 <= (mag_ext < thr_ext);
		end
	end

	assign flow.valid = v_s3;
	assign flow.below = below_s3;

endmodule

FILE: design/ffed_event_stage.sv
// Fall tracking state and result register of the free-fall event detector.
// Updates flag, duration and report phase per sample; uses ffed_pkg and ffed_result_if.
module ffed_event_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  ffed_pkg::mag_flow_t flow,
	output logic                flow_ready,
	input  ffed_pkg::cfg_t      cfg,
	ffed_result_if.source       result
);
	import ffed_pkg::*;

	logic                  falling_q;
	logic [DURATION_W-1:0] duration_q;
	logic [REPORT_W-1:0]   phase_q;
	logic                  out_valid_q;
	fall_event_t           event_q;
	logic [DURATION_W-1:0] shown_q;
	logic                  is_falling_q;

	logic                  take;
	logic [DURATION_W:0]   dur_sum;
	logic [DURATION_W-1:0] dur_sat;
	logic [REPORT_W-1:0]   interval;
	logic [REPORT_W-1:0]   phase_inc;
	logic                  falling_d;
	logic [DURATION_W-1:0] duration_d;
	logic [REPORT_W-1:0]   phase_d;
	fall_event_t           event_d;
	logic [DURATION_W-1:0] shown_d;

	// The result register frees up when empty or taken downstream
	assign flow_ready = !out_valid_q || result.ready;
	assign take       = flow.valid && flow_ready;

	// Saturating duration step and report interval (zero means every sample)
	assign dur_sum   = {1'b0, duration_q} + (DURATION_W + 1)'(cfg.sample_period);
	assign dur_sat   = dur_sum[DURATION_W] ? {DURATION_W{1'b1}} : dur_sum[DURATION_W-1:0];
	assign interval  = (cfg.still_report == '0) ? REPORT_W'(1) : cfg.still_report;
	assign phase_inc = phase_q + REPORT_W'(1);

	// Next state and event for the sample in hand
	always_comb begin
		falling_d  = falling_q;
		duration_d = duration_q;
		phase_d    = phase_q;
		event_d    = EV_NONE;
		if (flow.below) begin
			if (falling_q) begin
				duration_d = dur_sat;
				if (phase_inc == interval) begin
					event_d = EV_STILL;
					phase_d = '0;
				end else begin
					phase_d = phase_inc;
				end
			end else begin
				falling_d = 1'b1;
				phase_d   = '0;
				event_d   = EV_STARTED;
			end
			shown_d = duration_d;
		end else if (falling_q) begin
			event_d    = EV_ENDED;
			shown_d    = duration_q;
			falling_d  = 1'b0;
			duration_d = '0;
			phase_d    = '0;
		end else begin
			shown_d = duration_q;
		end
	end

	// Advance tracking state on each transfer into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			falling_q  <= 1'b0;
			duration_q <= '0;
			phase_q    <= '0;
		end else if (take) begin
			falling_q  <= falling_d;
			duration_q <= duration_d;
			phase_q    <= phase_d;
		end
	end

	// Hold the result until the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (flow_ready) begin
			out_valid_q <= flow.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			event_q      <= event_d;
			shown_q      <= shown_d;
			is_falling_q <= falling_d;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.fall_event       = event_q;
	assign result.fall_duration_ms = shown_q;
	assign result.is_falling       = is_falling_q;

endmodule

FILE: design/free_fall_event_detector_unit.sv
// Free-fall event detector, top level.
// Each sample passes the sample, squares, compare and result registers in turn.
// Throughput: one sample per cycle; the four-register chain (sample, squares,
// compare, result) stalls only when the result side holds off.
// Reset (arst_n low) clears the pipeline, the fall state and the registers to
// their defaults; after a threshold write, the squared threshold is registered from it.
module free_fall_event_detector_unit #(
	parameter int ACCEL_BITS = ffed_pkg::ACCEL_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ffed_sample_if.sink   sample,
	ffed_result_if.source result,
	ffed_cfg_if.sink      cfg
);
	import ffed_pkg::*;

	cfg_t      cfg_live;
	mag_flow_t flow;
	logic      flow_ready;

	// Configuration registers
	ffed_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_live)
	);

	// Squared magnitude and threshold compare
	ffed_mag_pipe #(
		.ACCEL_BITS (ACCEL_BITS)
	) u_mag_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.thr2       (cfg_live.thr2),
		.flow       (flow),
		.flow_ready (flow_ready)
	);

	// Fall tracking and result register
	ffed_event_stage u_event_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.flow       (flow),
		.flow_ready (flow_ready),
		.cfg        (cfg_live),
		.result     (result)
	);

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for free_fall_event_detector_unit.
// Uses ffed_pkg and the channel interfaces from ffed_if.sv. Samples and results
// are checked against an in-bench model of the fall state machine.
module tb_top;
	import ffed_pkg::*;

	localparam int SAMPLE_BITS    = ACCEL_BITS_DEF;
	localparam int PIPE_LATENCY   = 3;
	localparam int GAP_MAX        = 11;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	// Directed samples around the default threshold of 8000
	localparam int PROBE_COUNT = 15;
	localparam logic signed [ACCEL_FIELD_W-1:0] PROBES [PROBE_COUNT][3] = '{
		'{16'sd32767, 16'sd32767, 16'sd32767},
		'{16'sh8000, 16'sh8000, 16'sh8000},
		'{16'sd0, 16'sd0, 16'sd0},
		'{16'sd8000, 16'sd0, 16'sd0},
		'{16'sd7999, 16'sd0, 16'sd0},
		'{16'sd0, -16'sd7999, 16'sd0},
		'{16'sd0, 16'sd0, 16'sd4000},
		'{-16'sd4618, -16'sd4618, -16'sd4618},
		'{16'sd4618, -16'sd4618, 16'sd4618},
		'{16'sd1, -16'sd1, 16'sd1},
		'{16'sd4619, 16'sd4619, -16'sd4619},
		'{16'sd0, 16'sd0, -16'sd8000},
		'{16'sd1, -16'sd1, 16'sd1},
		'{16'sh8000, 16'sd0, 16'sd0},
		'{16'sd21845, -16'sd21846, 16'sd32767}
	};

	typedef struct {
		fall_event_t           code;
		logic [DURATION_W-1:0] duration;
		logic                  falling;
	} fall_report_t;

	// Tracks the fall state and holds the reports still owed by the block
	class fall_tracker;
		logic [THRESHOLD_W-1:0] threshold;
		logic [PERIOD_W-1:0]    period;
		logic [REPORT_W-1:0]    report_every;
		logic                   falling;
		logic [DURATION_W-1:0]  duration;
		logic [REPORT_W-1:0]    phase;
		fall_report_t           owed_reports[$];
		int                     mismatches;
		int                     checked;
		int                     event_count[4];

		function new();
			threshold    = THRESHOLD_RST;
			period       = PERIOD_RST;
			report_every = REPORT_RST;
			falling      = 1'b0;
			duration     = '0;
			phase        = '0;
			mismatches   = 0;
			checked      = 0;
			event_count  = '{0, 0, 0, 0};
		endfunction

		function int pending();
			return owed_reports.size();
		endfunction

		function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_THRESHOLD: threshold = value[THRESHOLD_W-1:0];
				REG_PERIOD: period = value[PERIOD_W-1:0];
				REG_REPORT: report_every = value[REPORT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] square_of(logic [ACCEL_FIELD_W-1:0] raw);
			logic [63:0] v;
			logic [63:0] m;
			v = 64'(raw[SAMPLE_BITS-1:0]);
			if (raw[SAMPLE_BITS-1]) v = v - (64'd1 << SAMPLE_BITS);
			m = raw[SAMPLE_BITS-1] ? (~v + 64'd1) : v;
			return m * m;
		endfunction

		// Advance the fall state by one sample and queue the report it causes
		function void note_sample(logic [ACCEL_FIELD_W-1:0] x, logic [ACCEL_FIELD_W-1:0] y,
				logic [ACCEL_FIELD_W-1:0] z);
			logic [63:0]           mag2;
			logic [63:0]           thr2;
			logic [REPORT_W-1:0]   interval;
			logic [DURATION_W:0]   grown;
			fall_report_t          rpt;
			mag2 = square_of(x) + square_of(y) + square_of(z);
			thr2 = 64'(threshold) * 64'(threshold);
			interval = (report_every == '0) ? REPORT_W'(1) : report_every;
			rpt.code = EV_NONE;
			if (mag2 < thr2) begin
				if (falling) begin
					grown = {1'b0, duration} + (DURATION_W + 1)'(period);
					duration = grown[DURATION_W] ? '1 : grown[DURATION_W-1:0];
					phase = phase + 1'b1;
					if (phase == interval) begin
						rpt.code = EV_STILL;
						phase = '0;
					end
				end else begin
					falling = 1'b1;
					phase = '0;
					rpt.code = EV_STARTED;
				end
				rpt.duration = duration;
			end else if (falling) begin
				rpt.code = EV_ENDED;
				rpt.duration = duration;
				falling = 1'b0;
				duration = '0;
				phase = '0;
			end else begin
				rpt.duration = duration;
			end
			rpt.falling = falling;
			event_count[rpt.code] += 1;
			owed_reports.push_back(rpt);
		endfunction

		// Compare one result transfer with the oldest owed report
		function void check_result(fall_report_t got);
			fall_report_t want;
			if (owed_reports.size() == 0) begin
				mismatches += 1;
				$display("%0t: result with nothing owed: event %s duration %0d falling %0b",
					$time, got.code.name(), got.duration, got.falling);
				return;
			end
			want = owed_reports.pop_front();
			checked += 1;
			if (got.code !== want.code) begin
				mismatches += 1;
				$display("%0t: fall_event expected %s actual %s", $time, want.code.name(),
					got.code.name());
			end
			if (got.duration !== want.duration) begin
				mismatches += 1;
				$display("%0t: fall_duration_ms expected %0d actual %0d", $time, want.duration,
					got.duration);
			end
			if (got.falling !== want.falling) begin
				mismatches += 1;
				$display("%0t: is_falling expected %0b actual %0b", $time, want.falling,
					got.falling);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet = 1'b0;
	int   samples_sent = 0;
	int   settings_used = 0;

	fall_tracker tracker = new();

	ffed_sample_if sample_ch();
	ffed_result_if result_ch();
	ffed_cfg_if    cfg_ch();

	free_fall_event_detector_unit #(
		.ACCEL_BITS(SAMPLE_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function int draw_gap();
		return quiet ? 0 : int'($urandom_range(0, GAP_MAX));
	endfunction

	// Drive one sample; entered and left at a falling edge
	task automatic send_sample(logic [ACCEL_FIELD_W-1:0] x, logic [ACCEL_FIELD_W-1:0] y,
			logic [ACCEL_FIELD_W-1:0] z);
		int gap;
		if (samples_sent % 48 == 0) quiet = ($urandom_range(0, 3) == 0);
		gap = draw_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.accel_x <= x;
		sample_ch.accel_y <= y;
		sample_ch.accel_z <= z;
		do @(posedge clk); while (!sample_ch.ready);
		tracker.note_sample(x, y, z);
		samples_sent++;
		@(negedge clk);
	endtask

	// Build a sample that lands below or above the threshold, or pure noise
	task automatic shaped_sample(bit want_below, int thr);
		int comp[3];
		int lim;
		int axis;
		int mag;
		for (int i = 0; i < 3; i++) comp[i] = int'($urandom_range(0, 65535)) - 32768;
		if (want_below && thr > 0) begin
			lim = thr / 2;
			for (int i = 0; i < 3; i++) begin
				comp[i] = $urandom_range(0, lim);
				if ($urandom_range(0, 1)) comp[i] = -comp[i];
			end
		end else if (!want_below && thr <= 32767) begin
			axis = $urandom_range(0, 2);
			mag = $urandom_range(thr, 32768);
			comp[axis] = (mag == 32768 || $urandom_range(0, 1)) ? -mag : mag;
		end
		send_sample(16'(comp[0]), 16'(comp[1]), 16'(comp[2]));
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.apply_reg(idx, value);
		@(negedge clk);
	endtask

	// Drain the pipe, load a setting, then stream fall runs and noise
	task automatic run_phase(logic [CFG_DATA_W-1:0] thr_data, logic [CFG_DATA_W-1:0] per_data,
			logic [CFG_DATA_W-1:0] rep_data, int n_items);
		int count;
		int len;
		int rep;
		int pick;
		sample_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		write_reg(REG_THRESHOLD, thr_data);
		write_reg(REG_PERIOD, per_data);
		write_reg(REG_REPORT, rep_data);
		write_reg(REG_SPARE, 16'($urandom));
		cfg_ch.valid <= 1'b0;
		settings_used++;
		rep = (rep_data[REPORT_W-1:0] == '0) ? 1 : int'(rep_data[REPORT_W-1:0]);
		count = 0;
		while (count < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 300);
				else len = $urandom_range(1, (3 * rep + 3 > 300) ? 300 : 3 * rep + 3);
				// Keep the phase close to its item budget
				if (len > n_items - count) len = n_items - count;
				repeat (len) shaped_sample(1'b1, int'(thr_data));
				count += len;
				len = $urandom_range(1, 3);
				repeat (len) shaped_sample(1'b0, int'(thr_data));
				count += len;
			end else begin
				shaped_sample(pick < 85 ? 1'b0 : 1'b1, int'(thr_data));
				count++;
			end
		end
	endtask

	// Result side: random hold-off before each transfer, check at the edge
	initial begin : result_sink
		int           hold;
		fall_report_t got;
		result_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			hold = draw_gap();
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got.code     = result_ch.fall_event;
			got.duration = result_ch.fall_duration_ms;
			got.falling  = result_ch.is_falling;
			tracker.check_result(got);
			@(negedge clk);
		end
	end

	// End the run when no channel has moved a transfer for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles, %0d reports still owed",
			WATCHDOG_LIMIT, tracker.pending());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		arst_n            = 1'b0;
		sample_ch.valid   = 1'b0;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		sample_ch.accel_z = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_THRESHOLD;
		cfg_ch.data       = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed samples at the reset settings
		settings_used++;
		for (int i = 0; i < PROBE_COUNT; i++)
			send_sample(PROBES[i][0], PROBES[i][1], PROBES[i][2]);

		// Extreme settings: everything falls, nothing falls, tiny and zero steps
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 600);
		run_phase(16'h0000, 16'h0000, 16'h0000, 100);
		run_phase(16'd1, 16'hFC01, 16'h0101, 100);
		run_phase(16'($urandom_range(500, 12000)), 16'hFC00, 16'hFF00, 120);

		// Random settings, mostly thresholds where both sides are reachable
		for (int p = 0; p < 8; p++)
			run_phase(($urandom_range(0, 3) == 0) ? 16'($urandom) :
					16'($urandom_range(100, 20000)),
				16'($urandom),
				{8'($urandom), 8'($urandom_range(0, 12))}, 130);

		// Drain, then leave room for any stray result
		sample_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (PIPE_LATENCY + 5) @(posedge clk);

		$display("ran %0d samples over %0d settings, %0d results checked", samples_sent,
			settings_used, tracker.checked);
		$display("falls started %0d, still-falling reports %0d, falls ended %0d",
			tracker.event_count[EV_STARTED], tracker.event_count[EV_STILL],
			tracker.event_count[EV_ENDED]);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
